// ===== sv/cst_pkg.sv =====
// Shared constants, types and helper functions of the CSV to separated text block.
`timescale 1ns / 1ps

package cst_pkg;

	// Character codes used by the parser.
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Separator value after reset.
	localparam logic [7:0] FS_RESET = 8'h09;

	// Parse state codes; codes above ST_CLOSE_STRING act as ST_BEGIN.
	localparam logic [2:0] ST_BEGIN        = 3'd0;
	localparam logic [2:0] ST_QUOTED       = 3'd1;
	localparam logic [2:0] ST_STRING       = 3'd2;
	localparam logic [2:0] ST_CLOSE_QUOTED = 3'd3;
	localparam logic [2:0] ST_CLOSE_STRING = 3'd4;

	// Error codes carried in a status word.
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_SEPARATOR = 3'd1;
	localparam logic [2:0] ERR_LF_QUOTED = 3'd2;
	localparam logic [2:0] ERR_AFTER_BLANK = 3'd3;
	localparam logic [2:0] ERR_TRUNCATED = 3'd4;

	// Default depth of the output queue.
	localparam int OUT_DEPTH_DEF = 4;

	// One result word.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic [2:0] error_code;
		logic       last;
	} result_t;

	// Status of the parser, seen by the top level.
	typedef struct packed {
		logic       halted;
		logic [2:0] parse_state;
	} parse_status_t;

	// Status of the output queue, seen by the top level.
	typedef struct packed {
		logic room;
		logic empty;
	} queue_status_t;

	// Build a character word.
	function automatic result_t mk_byte(input logic [7:0] b, input logic is_last);
		result_t r;
		r.out_byte   = b;
		r.has_byte   = 1'b1;
		r.error_code = ERR_NONE;
		r.last       = is_last;
		return r;
	endfunction

	// Build a status word.
	function automatic result_t mk_status(input logic [2:0] code);
		result_t r;
		r.out_byte   = 8'h00;
		r.has_byte   = 1'b0;
		r.error_code = code;
		r.last       = 1'b1;
		return r;
	endfunction

endpackage

// ===== sv/cst_if.sv =====
// Stream interfaces for the input bytes and the output words.
`timescale 1ns / 1ps

interface cst_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_data;

	modport source (output valid, output data_byte, output end_of_data, input ready);
	modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface cst_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic [2:0] error_code;
	logic       last;

	modport source (output valid, output out_byte, output has_byte, output error_code,
		output last, input ready);
	modport sink (input valid, input out_byte, input has_byte, input error_code,
		input last, output ready);
endinterface

// ===== sv/cst_parser.sv =====
// Parse state machine: turns one registered input byte into up to two result words.
`timescale 1ns / 1ps

module cst_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             data_byte,
	input  logic                   end_of_data,
	input  logic [7:0]             field_separator,
	output logic [1:0]             res_cnt,
	output cst_pkg::result_t       res0,
	output cst_pkg::result_t       res1,
	output cst_pkg::parse_status_t status
);

	logic [2:0] state_q;
	logic       halted_q;
	logic [2:0] state_d;
	logic       halted_d;
	logic       blank;

	assign blank = (data_byte == cst_pkg::CH_SPACE) || (data_byte == cst_pkg::CH_TAB);

	// Next state and result words for the current byte.
	always_comb begin
		state_d  = state_q;
		halted_d = halted_q;
		res_cnt  = 2'd0;
		res0     = '0;
		res1     = '0;
		if (halted_q) begin
			res_cnt = 2'd0;
		end else if (end_of_data) begin
			res_cnt = 2'd1;
			if (state_q != cst_pkg::ST_BEGIN) begin
				res0     = cst_pkg::mk_status(cst_pkg::ERR_TRUNCATED);
				halted_d = 1'b1;
			end else begin
				res0 = cst_pkg::mk_status(cst_pkg::ERR_NONE);
			end
		end else if (data_byte == cst_pkg::CH_CR) begin
			res_cnt = 2'd0;
		end else if (data_byte == field_separator) begin
			res_cnt  = 2'd1;
			res0     = cst_pkg::mk_status(cst_pkg::ERR_SEPARATOR);
			halted_d = 1'b1;
		end else begin
			unique case (state_q)
				cst_pkg::ST_QUOTED: begin
					priority if (data_byte == cst_pkg::CH_QUOTE) begin
						state_d = cst_pkg::ST_CLOSE_QUOTED;
					end else if (data_byte == cst_pkg::CH_LF) begin
						res_cnt  = 2'd1;
						res0     = cst_pkg::mk_status(cst_pkg::ERR_LF_QUOTED);
						halted_d = 1'b1;
					end else begin
						res_cnt = 2'd1;
						res0    = cst_pkg::mk_byte(data_byte, 1'b1);
					end
				end
				cst_pkg::ST_CLOSE_QUOTED: begin
					priority if (data_byte == cst_pkg::CH_COMMA) begin
						state_d = cst_pkg::ST_BEGIN;
						res_cnt = 2'd1;
						res0    = cst_pkg::mk_byte(field_separator, 1'b1);
					end else if (data_byte == cst_pkg::CH_LF) begin
						state_d = cst_pkg::ST_BEGIN;
						res_cnt = 2'd1;
						res0    = cst_pkg::mk_byte(cst_pkg::CH_LF, 1'b1);
					end else begin
						// A stray quote goes back out with the byte after it.
						state_d = cst_pkg::ST_QUOTED;
						res_cnt = 2'd2;
						res0    = cst_pkg::mk_byte(cst_pkg::CH_QUOTE, 1'b0);
						res1    = cst_pkg::mk_byte(data_byte, 1'b1);
					end
				end
				cst_pkg::ST_STRING: begin
					priority if (blank) begin
						state_d = cst_pkg::ST_CLOSE_STRING;
					end else if (data_byte == cst_pkg::CH_COMMA) begin
						state_d = cst_pkg::ST_BEGIN;
						res_cnt = 2'd1;
						res0    = cst_pkg::mk_byte(field_separator, 1'b1);
					end else if (data_byte == cst_pkg::CH_LF) begin
						state_d = cst_pkg::ST_BEGIN;
						res_cnt = 2'd1;
						res0    = cst_pkg::mk_byte(cst_pkg::CH_LF, 1'b1);
					end else begin
						res_cnt = 2'd1;
						res0    = cst_pkg::mk_byte(data_byte, 1'b1);
					end
				end
				cst_pkg::ST_CLOSE_STRING: begin
					priority if (blank) begin
						state_d = state_q;
					end else if (data_byte == cst_pkg::CH_COMMA) begin
						state_d = cst_pkg::ST_BEGIN;
						res_cnt = 2'd1;
						res0    = cst_pkg::mk_byte(field_separator, 1'b1);
					end else if (data_byte == cst_pkg::CH_LF) begin
						state_d = cst_pkg::ST_BEGIN;
						res_cnt = 2'd1;
						res0    = cst_pkg::mk_byte(cst_pkg::CH_LF, 1'b1);
					end else begin
						res_cnt  = 2'd1;
						res0     = cst_pkg::mk_status(cst_pkg::ERR_AFTER_BLANK);
						halted_d = 1'b1;
					end
				end
				default: begin
					// Field begin; unused codes behave the same way.
					priority if (blank) begin
						state_d = state_q;
					end else if (data_byte == cst_pkg::CH_QUOTE) begin
						state_d = cst_pkg::ST_QUOTED;
					end else if (data_byte == cst_pkg::CH_COMMA) begin
						res_cnt = 2'd2;
						res0    = cst_pkg::mk_byte(cst_pkg::CH_ZERO, 1'b0);
						res1    = cst_pkg::mk_byte(field_separator, 1'b1);
					end else if (data_byte == cst_pkg::CH_LF) begin
						res_cnt = 2'd2;
						res0    = cst_pkg::mk_byte(cst_pkg::CH_ZERO, 1'b0);
						res1    = cst_pkg::mk_byte(cst_pkg::CH_LF, 1'b1);
					end else begin
						state_d = cst_pkg::ST_STRING;
						res_cnt = 2'd1;
						res0    = cst_pkg::mk_byte(data_byte, 1'b1);
					end
				end
			endcase
		end
	end

	// State registers advance only when the byte is handed on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= cst_pkg::ST_BEGIN;
			halted_q <= 1'b0;
		end else if (step) begin
			state_q  <= state_d;
			halted_q <= halted_d;
		end
	end

	assign status.halted      = halted_q;
	assign status.parse_state = state_q;

endmodule

// ===== sv/cst_out_queue.sv =====
// Small output queue that takes up to two result words per cycle and gives one while txt_out is ready.
`timescale 1ns / 1ps

module cst_out_queue #(
	parameter int DEPTH = cst_pkg::OUT_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [1:0]             push_cnt,
	input  cst_pkg::result_t       push0,
	input  cst_pkg::result_t       push1,
	output cst_pkg::queue_status_t status,
	cst_out_if.source              txt_out
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_ROOM = CNT_W'(DEPTH - 2);

	cst_pkg::result_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] wr_ptr_p1;
	logic [PTR_W-1:0] wr_ptr_p2;
	logic [PTR_W-1:0] rd_ptr_p1;
	logic             pop;

	assign wr_ptr_p1 = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
	assign wr_ptr_p2 = (wr_ptr_p1 == PTR_LAST) ? '0 : wr_ptr_p1 + 1'b1;
	assign rd_ptr_p1 = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
	assign pop       = txt_out.valid && txt_out.ready;

	// Room for two words is judged on the count before this cycle's pop.
	assign status.room  = (count_q <= CNT_ROOM);
	assign status.empty = (count_q == '0);

	// Storage of the queued words.
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr_p1] <= push1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			unique case (push_cnt)
				2'd1:    wr_ptr_q <= wr_ptr_p1;
				2'd2:    wr_ptr_q <= wr_ptr_p2;
				default: wr_ptr_q <= wr_ptr_q;
			endcase
			if (pop) begin
				rd_ptr_q <= rd_ptr_p1;
			end
			count_q <= count_q + CNT_W'(push_cnt) - CNT_W'(pop);
		end
	end

	// Head of the queue drives the output channel.
	assign txt_out.valid      = (count_q != '0);
	assign txt_out.out_byte   = mem_q[rd_ptr_q].out_byte;
	assign txt_out.has_byte   = mem_q[rd_ptr_q].has_byte;
	assign txt_out.error_code = mem_q[rd_ptr_q].error_code;
	assign txt_out.last       = mem_q[rd_ptr_q].last;

endmodule

// ===== sv/csv_to_separated_text_core.sv =====
// Top level of the CSV to separated text converter.
//
//   Channel   Dir  Payload                                   Handshake
//   csv_in    in   data_byte, end_of_data                    valid/ready
//   txt_out   out  out_byte, has_byte, error_code, last      valid/ready
//   cfg       in   cfg_data (field_separator)                cfg_we, no wait
//
// One byte is accepted per cycle while the queue has room; the byte waits in the input register
// and is then written into the output queue, whose head is offered on txt_out.
// An item that yields two words writes both into the output queue at once; they leave one by one.
// Input stalls when the queue holds more than OUT_DEPTH - 2 words while a byte waits.
// Reset clears the parse state, the halt flag, the queue and sets the separator to tab.
// A stall on txt_out never drops or repeats a word; after a fault the block stays halted.
`timescale 1ns / 1ps

module csv_to_separated_text_core #(
	parameter int OUT_DEPTH = cst_pkg::OUT_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data,
	cst_in_if.sink     csv_in,
	cst_out_if.source  txt_out
);

	logic                   valid_s1;
	logic [7:0]             data_s1;
	logic                   eod_s1;
	logic [7:0]             field_sep_q;
	logic                   step;
	logic [1:0]             res_cnt;
	cst_pkg::result_t       res0;
	cst_pkg::result_t       res1;
	cst_pkg::parse_status_t parse_st;
	cst_pkg::queue_status_t queue_st;
	logic                   accept;

	// Separator register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_sep_q <= cst_pkg::FS_RESET;
		end else if (cfg_we) begin
			field_sep_q <= cfg_data;
		end
	end

	// Input register: the held byte moves on when the queue has room for two words.
	assign step         = valid_s1 && queue_st.room;
	assign csv_in.ready = !valid_s1 || queue_st.room;
	assign accept       = csv_in.valid && csv_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (csv_in.ready) begin
			valid_s1 <= csv_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= csv_in.data_byte;
			eod_s1  <= csv_in.end_of_data;
		end
	end

	cst_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.data_byte       (data_s1),
		.end_of_data     (eod_s1),
		.field_separator (field_sep_q),
		.res_cnt         (res_cnt),
		.res0            (res0),
		.res1            (res1),
		.status          (parse_st)
	);

	cst_out_queue #(
		.DEPTH (OUT_DEPTH)
	) u_out_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (step ? res_cnt : 2'd0),
		.push0    (res0),
		.push1    (res1),
		.status   (queue_st),
		.txt_out  (txt_out)
	);

	// A halted parser produces no words.
	a_halted_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(step && parse_st.halted) |-> (res_cnt == 2'd0))
		else $error("halted parser produced a word");

	// Any error status halts the parser from the next cycle on.
	a_error_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_cnt != 2'd0 && res0.error_code != cst_pkg::ERR_NONE) |=> parse_st.halted)
		else $error("error word without halt");

	// Once halted, the parser stays halted.
	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		parse_st.halted |=> parse_st.halted)
		else $error("halt flag cleared without reset");

	// A queue without room must be offering a word.
	a_full_offers: assert property (@(posedge clk) disable iff (!arst_n)
		!queue_st.room |-> (txt_out.valid && !queue_st.empty))
		else $error("queue reports no room while empty");

endmodule

// ===== dv/cst_text_checker.sv =====
// Predictor and scoreboard that watch the CSV input and text output channels.
`timescale 1ns / 1ps

module cst_text_checker
	import cst_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data,
	cst_in_if          in_ch,
	cst_out_if         out_ch,
	input  logic       end_check,
	output int         errors,
	output int         pending,
	output logic [2:0] pred_state,
	output logic [7:0] pred_sep,
	output logic       pred_halted
);

	// Words the block still owes, oldest first.
	result_t owed_words[$];

	// Print one line per mismatch and count it.
	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] txt_out mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
		errors++;
	endtask

	task automatic owe_char(input logic [7:0] b, input logic is_last);
		result_t w;
		w.out_byte   = b;
		w.has_byte   = 1'b1;
		w.error_code = ERR_NONE;
		w.last       = is_last;
		owed_words.push_back(w);
	endtask

	task automatic owe_status(input logic [2:0] code);
		result_t w;
		w.out_byte   = 8'h00;
		w.has_byte   = 1'b0;
		w.error_code = code;
		w.last       = 1'b1;
		owed_words.push_back(w);
	endtask

	// A fault leaves one status word and freezes the parser until reset.
	task automatic halt_with(input logic [2:0] code);
		pred_halted = 1'b1;
		owe_status(code);
	endtask

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB;
	endfunction

	// Advance the parser by one input word and queue the words it causes.
	task automatic predict_text(input logic [7:0] c, input logic eod);
		if (pred_halted)
			return;
		if (eod) begin
			if (pred_state != ST_BEGIN)
				halt_with(ERR_TRUNCATED);
			else
				owe_status(ERR_NONE);
			return;
		end
		// Carriage returns vanish ahead of the separator and state tests.
		if (c == CH_CR)
			return;
		if (c == pred_sep) begin
			halt_with(ERR_SEPARATOR);
			return;
		end
		case (pred_state)
			ST_QUOTED: begin
				if (c == CH_QUOTE)
					pred_state = ST_CLOSE_QUOTED;
				else if (c == CH_LF)
					halt_with(ERR_LF_QUOTED);
				else
					owe_char(c, 1'b1);
			end
			ST_CLOSE_QUOTED: begin
				if (c == CH_COMMA) begin
					pred_state = ST_BEGIN;
					owe_char(pred_sep, 1'b1);
				end else if (c == CH_LF) begin
					pred_state = ST_BEGIN;
					owe_char(CH_LF, 1'b1);
				end else begin
					// The closing quote was part of the text after all.
					pred_state = ST_QUOTED;
					owe_char(CH_QUOTE, 1'b0);
					owe_char(c, 1'b1);
				end
			end
			ST_STRING: begin
				if (is_blank(c)) begin
					pred_state = ST_CLOSE_STRING;
				end else if (c == CH_COMMA) begin
					pred_state = ST_BEGIN;
					owe_char(pred_sep, 1'b1);
				end else if (c == CH_LF) begin
					pred_state = ST_BEGIN;
					owe_char(CH_LF, 1'b1);
				end else begin
					owe_char(c, 1'b1);
				end
			end
			ST_CLOSE_STRING: begin
				if (is_blank(c)) begin
				end else if (c == CH_COMMA) begin
					pred_state = ST_BEGIN;
					owe_char(pred_sep, 1'b1);
				end else if (c == CH_LF) begin
					pred_state = ST_BEGIN;
					owe_char(CH_LF, 1'b1);
				end else begin
					halt_with(ERR_AFTER_BLANK);
				end
			end
			default: begin
				if (is_blank(c)) begin
				end else if (c == CH_QUOTE) begin
					pred_state = ST_QUOTED;
				end else if (c == CH_COMMA) begin
					owe_char(CH_ZERO, 1'b0);
					owe_char(pred_sep, 1'b1);
				end else if (c == CH_LF) begin
					owe_char(CH_ZERO, 1'b0);
					owe_char(CH_LF, 1'b1);
				end else begin
					pred_state = ST_STRING;
					owe_char(c, 1'b1);
				end
			end
		endcase
	endtask

	// Compare delivered words first, then predict from the accepted input word.
	always @(posedge clk or negedge arst_n) begin : track_words
		result_t got;
		result_t want;
		if (!arst_n) begin
			owed_words.delete();
			pred_state  = ST_BEGIN;
			pred_sep    = FS_RESET;
			pred_halted = 1'b0;
			errors      = 0;
			pending     = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got.out_byte   = out_ch.out_byte;
				got.has_byte   = out_ch.has_byte;
				got.error_code = out_ch.error_code;
				got.last       = out_ch.last;
				if (owed_words.size() == 0) begin
					report_mismatch("word with none owed", got, 0);
				end else begin
					want = owed_words.pop_front();
					if (got.out_byte !== want.out_byte)
						report_mismatch("out_byte", got.out_byte, want.out_byte);
					if (got.has_byte !== want.has_byte)
						report_mismatch("has_byte", got.has_byte, want.has_byte);
					if (got.error_code !== want.error_code)
						report_mismatch("error_code", got.error_code, want.error_code);
					if (got.last !== want.last)
						report_mismatch("last", got.last, want.last);
				end
			end
			if (in_ch.valid && in_ch.ready)
				predict_text(in_ch.data_byte, in_ch.end_of_data);
			if (cfg_we)
				pred_sep = cfg_data;
			pending = owed_words.size();
		end
	end

	// Words still owed when the run ends were lost.
	always @(posedge end_check) begin
		if (owed_words.size() != 0)
			report_mismatch("words never delivered", owed_words.size(), 0);
	end

endmodule

// ===== dv/csv_to_separated_text_core_test.sv =====
// Stimulus, clock, reset and verdict for the CSV to separated text block.
`timescale 1ns / 1ps

module csv_to_separated_text_core_test;
	import cst_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 60;
	localparam int PHASE_ITEMS  = 310;
	localparam int NUM_PHASES   = 6;
	localparam logic [7:0] CH_A = 8'h61;
	localparam logic [7:0] CH_B = 8'h62;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_data = 8'h00;
	logic       end_check = 1'b0;

	int         check_errors;
	int         words_pending;
	logic [2:0] pred_state;
	logic [7:0] pred_sep;
	logic       pred_halted;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	int items_sent = 0;
	int quiet_cycles = 0;

	// Opening text under the reset separator: skipped and trailing blanks, extreme
	// bytes, empty fields, doubled quotes, a quote re-emitted with the next byte.
	logic [7:0] opening_text [24] = '{
		8'h20, 8'h00, 8'hFF, 8'h20, 8'h0D, 8'h20, 8'h2C,
		8'h2C,
		8'h22, 8'h61, 8'h22, 8'h22, 8'h62, 8'h22, 8'h2C,
		8'h22, 8'h71, 8'h22, 8'h7A, 8'h22, 8'h0A,
		8'h0A,
		8'h6B, 8'h0A
	};

	cst_in_if  csv_in();
	cst_out_if txt_out();

	csv_to_separated_text_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.csv_in   (csv_in),
		.txt_out  (txt_out)
	);

	cst_text_checker u_text_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.in_ch       (csv_in),
		.out_ch      (txt_out),
		.end_check   (end_check),
		.errors      (check_errors),
		.pending     (words_pending),
		.pred_state  (pred_state),
		.pred_sep    (pred_sep),
		.pred_halted (pred_halted)
	);

	always #1 clk = ~clk;

	initial begin
		csv_in.valid       = 1'b0;
		csv_in.data_byte   = 8'h00;
		csv_in.end_of_data = 1'b0;
		txt_out.ready      = 1'b0;
	end

	// Receiver: random stalls, and a long hold-off whenever one is requested.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				txt_out.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			txt_out.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog on cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if ((csv_in.valid && csv_in.ready) || (txt_out.valid && txt_out.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Offer one word, with an optional idle gap first; returns at the falling edge after
	// the word is taken.
	task automatic send_item(input logic [7:0] b, input logic eod);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			csv_in.valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(negedge clk);
		end
		csv_in.valid       <= 1'b1;
		csv_in.data_byte   <= b;
		csv_in.end_of_data <= eod;
		@(posedge clk);
		while (!csv_in.ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// Let every owed word arrive, then give in-flight bytes time to settle.
	task automatic quiesce();
		csv_in.valid <= 1'b0;
		while (words_pending != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_sep(input logic [7:0] value);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we   <= 1'b0;
		@(negedge clk);
	endtask

	// Text byte for an unquoted field: nothing that ends, splits or breaks it.
	function automatic logic [7:0] pick_plain(input bit allow_quote);
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == pred_sep || b == CH_CR || b == CH_LF || b == CH_COMMA ||
			b == CH_SPACE || b == CH_TAB || (!allow_quote && b == CH_QUOTE));
		return b;
	endfunction

	// Text byte inside quotes; after a closing quote a comma would end the field.
	function automatic logic [7:0] pick_quoted(input bit no_comma);
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == pred_sep || b == CH_LF || b == CH_QUOTE || (no_comma && b == CH_COMMA));
		return b;
	endfunction

	function automatic logic [7:0] pick_blank();
		logic [7:0] b;
		b = $urandom_range(1) ? CH_SPACE : CH_TAB;
		if (b == pred_sep)
			b = (b == CH_SPACE) ? CH_TAB : CH_SPACE;
		return b;
	endfunction

	// True when the byte would not fault the parser in its present state.
	function automatic bit harmless(input logic [7:0] b);
		if (b == CH_CR)
			return 1'b1;
		if (b == pred_sep)
			return 1'b0;
		case (pred_state)
			ST_QUOTED:       return b != CH_LF;
			ST_CLOSE_STRING: return b == CH_SPACE || b == CH_TAB || b == CH_COMMA || b == CH_LF;
			default:         return 1'b1;
		endcase
	endfunction

	// One field: leading blanks, then empty, unquoted or quoted text.
	task automatic send_field();
		int kind;
		int len;
		kind = $urandom_range(3);
		repeat ($urandom_range(2)) send_item(pick_blank(), 1'b0);
		if (kind == 1) begin
			len = $urandom_range(1, 6);
			send_item(pick_plain(1'b0), 1'b0);
			repeat (len - 1) send_item(pick_plain(1'b1), 1'b0);
			repeat ($urandom_range(2)) send_item(pick_blank(), 1'b0);
			if ($urandom_range(3) == 0)
				send_item(CH_CR, 1'b0);
		end else if (kind >= 2) begin
			len = $urandom_range(0, 5);
			send_item(CH_QUOTE, 1'b0);
			repeat (len) begin
				case ($urandom_range(7))
					0: begin
						send_item(CH_QUOTE, 1'b0);
						send_item(CH_QUOTE, 1'b0);
					end
					1: begin
						// A stray closing quote followed by more text.
						send_item(CH_QUOTE, 1'b0);
						send_item(pick_quoted(1'b1), 1'b0);
					end
					default: send_item(pick_quoted(1'b0), 1'b0);
				endcase
			end
			send_item(CH_QUOTE, 1'b0);
		end
	endtask

	task automatic send_record();
		int nf;
		nf = $urandom_range(1, 4);
		for (int i = 0; i < nf; i++) begin
			send_field();
			if (i < nf - 1)
				send_item(CH_COMMA, 1'b0);
		end
		if ($urandom_range(2) == 0)
			send_item(CH_CR, 1'b0);
		send_item(CH_LF, 1'b0);
	endtask

	// A burst of random bytes that stay clear of faults, then back to a field start.
	task automatic send_noise();
		logic [7:0] b;
		repeat ($urandom_range(1, 8)) begin
			if (pred_state == ST_BEGIN && $urandom_range(7) == 0) begin
				send_item(8'($urandom_range(255)), 1'b1);
			end else begin
				do
					b = 8'($urandom_range(255));
				while (!harmless(b));
				send_item(b, 1'b0);
			end
		end
		if (pred_state == ST_QUOTED)
			send_item(CH_QUOTE, 1'b0);
		if (pred_state != ST_BEGIN)
			send_item(CH_LF, 1'b0);
	endtask

	// Main stimulus: opening text, random phases, one fault, then the verdict.
	initial begin : stimulus
		logic [7:0] sep;
		logic [2:0] fault_kind;
		int phase_end;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (opening_text[i])
			send_item(opening_text[i], 1'b0);
		send_item(8'($urandom_range(255)), 1'b1);

		for (int p = 0; p < NUM_PHASES; p++) begin
			quiesce();
			case (p)
				0: sep = 8'hFF;
				1: sep = 8'h00;
				2: sep = CH_CR;
				3: sep = CH_SPACE;
				4: begin
					do
						sep = 8'($urandom_range(255));
					while (sep == CH_LF || sep == CH_COMMA || sep == CH_QUOTE);
				end
				default: sep = FS_RESET;
			endcase
			write_sep(sep);
			case (p % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					hold_req       = 1'b1;
				end
				1: begin
					send_idle_pct  = 52;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 52;
				end
				default: begin
					send_idle_pct  = 20;
					recv_stall_pct = 20;
				end
			endcase
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				case ($urandom_range(9))
					7, 9: send_noise();
					8:    send_item(8'($urandom_range(255)), 1'b1);
					default: send_record();
				endcase
			end
		end

		// Only one fault per run, since reset comes once; the seed picks which.
		quiesce();
		send_idle_pct  = 20;
		recv_stall_pct = 20;
		fault_kind = 3'($urandom_range(ERR_SEPARATOR, ERR_TRUNCATED));
		case (fault_kind)
			ERR_SEPARATOR: send_item(pred_sep, 1'b0);
			ERR_LF_QUOTED: begin
				send_item(CH_QUOTE, 1'b0);
				send_item(CH_A, 1'b0);
				send_item(CH_LF, 1'b0);
			end
			ERR_AFTER_BLANK: begin
				send_item(CH_A, 1'b0);
				send_item(CH_SPACE, 1'b0);
				send_item(CH_B, 1'b0);
			end
			default: begin
				send_item(CH_A, 1'b0);
				send_item(8'($urandom_range(255)), 1'b1);
			end
		endcase

		// The halted block must swallow everything, before and after a separator change.
		repeat (10) send_item(8'($urandom_range(255)), $urandom_range(3) == 0);
		quiesce();
		write_sep(CH_COMMA);
		repeat (10) send_item(8'($urandom_range(255)), $urandom_range(3) == 0);

		quiesce();
		end_check <= 1'b1;
		@(negedge clk);
		if (check_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
sv/cst_pkg.sv
sv/cst_if.sv
sv/cst_parser.sv
sv/cst_out_queue.sv
sv/csv_to_separated_text_core.sv
dv/cst_text_checker.sv
dv/csv_to_separated_text_core_test.sv
